>>> src/emcc_pkg.sv
package emcc_pkg;

    localparam int AddrW = 5;
    localparam int DataW = 32;

    // unit codes of an advance
    localparam logic [1:0] KIND_MS     = 2'd0;
    localparam logic [1:0] KIND_MINUTE = 2'd1;
    localparam logic [1:0] KIND_HOUR   = 2'd2;

    localparam logic [21:0] MsPerMinute = 22'd60000;
    localparam logic [21:0] MsPerHour   = 22'd3600000;

    // reciprocal constants: x / d == (x * Recip) >> Shift over the needed range
    localparam logic [28:0] Recip1000      = 29'd274877907;
    localparam int          Recip1000Shift = 38;
    localparam logic [23:0] Recip60        = 24'd8947849;
    localparam int          Recip60Shift   = 29;
    localparam logic [11:0] Recip24        = 12'd2731;
    localparam int          Recip24Shift   = 16;

    localparam logic [6:0] SecPerMin  = 7'd60;
    localparam logic [6:0] MinPerHour = 7'd60;
    localparam logic [6:0] HourPerDay = 7'd24;

    typedef enum logic [2:0] {
        REG_YEAR   = 3'd0,
        REG_MONTH  = 3'd1,
        REG_DAY    = 3'd2,
        REG_HOUR   = 3'd3,
        REG_MINUTE = 3'd4,
        REG_SECOND = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] amount;
    } req_t;

    typedef struct packed {
        logic [31:0] elapsed_ms;
        logic [5:0]  out_second;
        logic [5:0]  out_minute;
        logic [4:0]  out_hour;
        logic [4:0]  out_day;
        logic [3:0]  out_month;
        logic [15:0] out_year;
    } rsp_t;

    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } cfg_t;

    typedef enum logic [3:0] {
        CMD_IDLE,
        CMD_LOAD,
        CMD_ADD,
        CMD_DIV_MS,
        CMD_DIV_SEC,
        CMD_FOLD_SEC,
        CMD_DIV_MIN,
        CMD_FOLD_MIN,
        CMD_DIV_HOUR,
        CMD_FOLD_HOUR,
        CMD_WALK,
        CMD_EMIT
    } dp_cmd_t;

    typedef struct packed {
        logic walk_done;
    } dp_stat_t;

    // fixed month lengths, no leap years; an invalid month counts as 31 days
    function automatic logic [4:0] month_days(input logic [3:0] month);
        logic [4:0] days;
        case (month) inside
            4'd2:                   days = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: days = 5'd30;
            default:                days = 5'd31;
        endcase
        return days;
    endfunction

endpackage

>>> src/emcc_regs.sv
module emcc_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [emcc_pkg::AddrW-1:0]  paddr,
    input  logic [emcc_pkg::DataW-1:0]  pwdata,
    output logic [emcc_pkg::DataW-1:0]  prdata,
    output logic                        pready,
    output emcc_pkg::cfg_t              cfg,
    output logic                        cfg_clear
);
    import emcc_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr;
    logic     idx_ok;

    assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        prdata = '0;
        idx_ok = 1'b1;
        unique case (idx)
            REG_YEAR:   prdata = DataW'(cfg_reg.year);
            REG_MONTH:  prdata = DataW'(cfg_reg.month);
            REG_DAY:    prdata = DataW'(cfg_reg.day);
            REG_HOUR:   prdata = DataW'(cfg_reg.hour);
            REG_MINUTE: prdata = DataW'(cfg_reg.minute);
            REG_SECOND: prdata = DataW'(cfg_reg.second);
            default:    idx_ok = 1'b0;
        endcase
    end

    // any origin write restarts the elapsed count
    assign cfg_clear = wr && idx_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.year   <= 16'd2026;
            cfg_reg.month  <= 4'd1;
            cfg_reg.day    <= 5'd1;
            cfg_reg.hour   <= '0;
            cfg_reg.minute <= '0;
            cfg_reg.second <= '0;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_YEAR:   cfg_reg.year   <= pwdata[15:0];
                REG_MONTH:  cfg_reg.month  <= pwdata[3:0];
                REG_DAY:    cfg_reg.day    <= pwdata[4:0];
                REG_HOUR:   cfg_reg.hour   <= pwdata[4:0];
                REG_MINUTE: cfg_reg.minute <= pwdata[5:0];
                REG_SECOND: cfg_reg.second <= pwdata[5:0];
                default:    ;
            endcase
        end
    end

endmodule

>>> src/emcc_ctrl.sv
module emcc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    input  emcc_pkg::dp_stat_t stat,
    output emcc_pkg::dp_cmd_t  cmd
);
    import emcc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_DIV_MS,
        S_DIV_SEC,
        S_FOLD_SEC,
        S_DIV_MIN,
        S_FOLD_MIN,
        S_DIV_HOUR,
        S_FOLD_HOUR,
        S_WALK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_IDLE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                cmd        = CMD_ADD;
                state_next = S_DIV_MS;
            end
            S_DIV_MS:
            begin
                cmd        = CMD_DIV_MS;
                state_next = S_DIV_SEC;
            end
            S_DIV_SEC:
            begin
                cmd        = CMD_DIV_SEC;
                state_next = S_FOLD_SEC;
            end
            S_FOLD_SEC:
            begin
                cmd        = CMD_FOLD_SEC;
                state_next = S_DIV_MIN;
            end
            S_DIV_MIN:
            begin
                cmd        = CMD_DIV_MIN;
                state_next = S_FOLD_MIN;
            end
            S_FOLD_MIN:
            begin
                cmd        = CMD_FOLD_MIN;
                state_next = S_DIV_HOUR;
            end
            S_DIV_HOUR:
            begin
                cmd        = CMD_DIV_HOUR;
                state_next = S_FOLD_HOUR;
            end
            S_FOLD_HOUR:
            begin
                cmd        = CMD_FOLD_HOUR;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (!stat.walk_done)
                    cmd = CMD_WALK;
                else if (!rsp_valid_reg || !rsp_stall)
                begin
                    // output register is free or drains this cycle
                    cmd        = CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd == CMD_EMIT)
            rsp_valid_next = 1'b1;
        else if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

>>> src/emcc_dp.sv
module emcc_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  emcc_pkg::dp_cmd_t  cmd,
    input  emcc_pkg::req_t     req,
    input  emcc_pkg::cfg_t     cfg,
    input  logic               cfg_clear,
    output emcc_pkg::dp_stat_t stat,
    output emcc_pkg::rsp_t     rsp
);
    import emcc_pkg::*;

    typedef struct packed {
        logic [1:0] carry;
        logic [6:0] val;
    } fold_t;

    // reduce v below radix; v stays under three times radix
    function automatic fold_t fold(input logic [6:0] v, input logic [6:0] radix);
        fold_t      f;
        logic [6:0] twice;
        twice = 7'(radix << 1);
        if (v >= twice)
        begin
            f.carry = 2'd2;
            f.val   = v - twice;
        end
        else if (v >= radix)
        begin
            f.carry = 2'd1;
            f.val   = v - radix;
        end
        else
        begin
            f.carry = 2'd0;
            f.val   = v;
        end
        return f;
    endfunction

    logic [31:0] elapsed_reg;
    logic [31:0] addend_reg;
    logic [60:0] prod_reg;
    logic [22:0] num_reg;
    logic [5:0]  sec_reg;
    logic [5:0]  min_reg;
    logic [4:0]  hour_reg;
    logic [6:0]  day_reg;
    logic [3:0]  month_reg;
    logic [15:0] year_reg;
    rsp_t        rsp_reg;

    // scaling of the advance
    logic [21:0] scale;
    logic [53:0] scale_prod;
    logic [31:0] addend_next;

    // shared reciprocal multiplier
    logic [31:0] mul_a;
    logic [28:0] mul_b;
    logic [60:0] prod_next;

    logic [22:0] tsec;
    logic [16:0] q_sec;
    logic [10:0] q_min;
    logic [5:0]  q_hour;
    logic [22:0] sec_low;
    logic [16:0] min_low;
    logic [10:0] hour_low;
    fold_t       sec_fold;
    fold_t       min_fold;
    fold_t       hour_fold;
    logic [4:0]  dim;

    assign scale      = (req.kind == KIND_HOUR) ? MsPerHour : MsPerMinute;
    assign scale_prod = req.amount * scale;

    always_comb
    begin
        case (req.kind)
            KIND_MS:     addend_next = req.amount;
            KIND_MINUTE: addend_next = scale_prod[31:0];
            KIND_HOUR:   addend_next = scale_prod[31:0];
            default:     addend_next = '0;
        endcase
    end

    assign tsec   = prod_reg[Recip1000Shift +: 23];
    assign q_sec  = prod_reg[Recip60Shift +: 17];
    assign q_min  = prod_reg[Recip60Shift +: 11];
    assign q_hour = prod_reg[Recip24Shift +: 6];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd)
            CMD_DIV_MS:
            begin
                mul_a = elapsed_reg;
                mul_b = Recip1000;
            end
            CMD_DIV_SEC:
            begin
                mul_a = 32'(tsec);
                mul_b = 29'(Recip60);
            end
            CMD_DIV_MIN:
            begin
                mul_a = 32'(num_reg[16:0]);
                mul_b = 29'(Recip60);
            end
            CMD_DIV_HOUR:
            begin
                mul_a = 32'(num_reg[10:0]);
                mul_b = 29'(Recip24);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // remainders from the registered quotients
    assign sec_low  = num_reg - 23'(q_sec) * 23'(SecPerMin);
    assign min_low  = num_reg[16:0] - 17'(q_min) * 17'(MinPerHour);
    assign hour_low = num_reg[10:0] - 11'(q_hour) * 11'(HourPerDay);

    assign sec_fold  = fold(7'(cfg.second) + 7'(sec_low[5:0]), SecPerMin);
    assign min_fold  = fold(7'(cfg.minute) + 7'(min_low[5:0]), MinPerHour);
    assign hour_fold = fold(7'(cfg.hour) + 7'(hour_low[4:0]), HourPerDay);

    assign dim            = month_days(month_reg);
    assign stat.walk_done = (day_reg <= 7'(dim));
    assign rsp            = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            elapsed_reg <= '0;
        else if (cfg_clear)
            elapsed_reg <= '0;
        else if (cmd == CMD_ADD)
            elapsed_reg <= elapsed_reg + addend_reg;
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LOAD:
                addend_reg <= addend_next;
            CMD_DIV_MS, CMD_DIV_MIN, CMD_DIV_HOUR:
                prod_reg <= prod_next;
            CMD_DIV_SEC:
            begin
                num_reg  <= tsec;
                prod_reg <= prod_next;
            end
            CMD_FOLD_SEC:
            begin
                sec_reg <= sec_fold.val[5:0];
                num_reg <= 23'(q_sec) + 23'(sec_fold.carry);
            end
            CMD_FOLD_MIN:
            begin
                min_reg <= min_fold.val[5:0];
                num_reg <= 23'(q_min) + 23'(min_fold.carry);
            end
            CMD_FOLD_HOUR:
            begin
                hour_reg  <= hour_fold.val[4:0];
                day_reg   <= 7'(cfg.day) + 7'(q_hour) + 7'(hour_fold.carry);
                month_reg <= cfg.month;
                year_reg  <= cfg.year;
            end
            CMD_WALK:
            begin
                day_reg <= day_reg - 7'(dim);
                // december and invalid months above it roll into a new year
                if (month_reg >= 4'd12)
                begin
                    month_reg <= 4'd1;
                    year_reg  <= year_reg + 16'd1;
                end
                else
                    month_reg <= month_reg + 4'd1;
            end
            CMD_EMIT:
            begin
                rsp_reg.elapsed_ms <= elapsed_reg;
                rsp_reg.out_second <= sec_reg;
                rsp_reg.out_minute <= min_reg;
                rsp_reg.out_hour   <= hour_reg;
                rsp_reg.out_day    <= day_reg[4:0];
                rsp_reg.out_month  <= month_reg;
                rsp_reg.out_year   <= year_reg;
            end
            default:
                ;
        endcase
    end

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_clear |=> elapsed_reg == '0)
        else $error("elapsed count not cleared by origin write");

    a_walk_needed: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == CMD_WALK |-> !stat.walk_done)
        else $error("month step taken with day inside the month");

    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == CMD_EMIT |-> stat.walk_done)
        else $error("word emitted before the month walk finished");

    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == CMD_FOLD_HOUR |=>
            (sec_reg < 6'd60) && (min_reg < 6'd60) && (hour_reg < 5'd24))
        else $error("time of day out of range after carry cascade");

endmodule

>>> src/elapsed_ms_calendar_clock.sv
// elapsed millisecond counter with a calendar view of origin plus elapsed time
//
// req channel: req_valid/req_stall carry one word {kind, amount}. kind selects
// milliseconds, minutes or hours (other codes add nothing); amount zero reads.
// rsp channel: rsp_valid/rsp_stall carry one word per request: the wrapped
// millisecond count and second, minute, hour, day, month, year.
// config: apb-style write of the origin fields at 4*index; any origin write
// restarts the elapsed count at zero. pready is always high.
//
// the carry cascade runs through one shared reciprocal multiplier, so one
// request is in flight at a time: a new word is taken only once the last
// one has been emitted. the month walk steps one month per cycle.
// the response sits in an output register; a stall there holds it, and the
// next request is still accepted and worked up to its final step.
// reset: count zero, origin 2026-01-01 00:00:00, no response pending.
module elapsed_ms_calendar_clock (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  emcc_pkg::req_t              req,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output emcc_pkg::rsp_t              rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [emcc_pkg::AddrW-1:0]  paddr,
    input  logic [emcc_pkg::DataW-1:0]  pwdata,
    output logic [emcc_pkg::DataW-1:0]  prdata,
    output logic                        pready
);
    import emcc_pkg::*;

    cfg_t     cfg;
    logic     cfg_clear;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    emcc_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cfg       (cfg),
        .cfg_clear (cfg_clear)
    );

    emcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    emcc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .cfg       (cfg),
        .cfg_clear (cfg_clear),
        .stat      (stat),
        .rsp       (rsp)
    );

endmodule
